[rtl/transformed_aabb_collision_scan_unit_defines.svh]
// assertion macros for the transformed box collision scan unit
// used by the checker module; no other dependencies
`ifndef TRANSFORMED_AABB_COLLISION_SCAN_UNIT_DEFINES_SVH
`define TRANSFORMED_AABB_COLLISION_SCAN_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TACS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tacs check failed");

// next-cycle implication, disabled during reset
`define TACS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tacs check failed");

`endif

[rtl/tacs_pkg.sv]
// shared types, constants and saturation helpers for the collision scan unit
// no dependencies
package tacs_pkg;

	localparam int WORDS_PER_OBJ = 18;
	localparam int BOX_WORDS     = 6;
	localparam logic [4:0] ENABLE_WORD = 5'd18;
	localparam logic [4:0] MAT_BASE    = 5'd6;
	localparam logic [4:0] TRANS_BASE  = 5'd9;
	localparam logic [1:0] LAST_COL    = 2'd2;
	localparam logic [1:0] LAST_ROW    = 2'd2;
	localparam logic [2:0] LAST_CORNER = 3'd7;
	localparam logic [2:0] BOX_DONE    = 3'd6;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCAN, ST_BOX, ST_TRD, ST_TLD, ST_MUL, ST_ACC, ST_FOLD, ST_CHECK, ST_DONE
	} state_t;

	typedef struct packed {
		logic       wr;
		logic       ld_player;
		logic       clr;
		logic       rd_en;
		logic [4:0] rd_word;
		logic       cap_box;
		logic [2:0] box_sel;
		logic       ld_acc;
		logic       mul;
		logic       acc;
		logic       fold;
		logic [1:0] row;
		logic [1:0] col;
		logic [2:0] corner;
	} cmd_t;

	typedef struct packed {
		logic en_cur;
		logic overlap;
	} stat_t;

	function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'(S32_MAX))
			r = S32_MAX;
		else if (v < 48'(S32_MIN))
			r = S32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'(S32_MAX))
			r = S32_MAX;
		else if (v < 34'(S32_MIN))
			r = S32_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

[rtl/tacs_dp.sv]
// datapath: object word memory, enable bits, one shared multiplier, min/max and overlap
// depends on tacs_pkg
module tacs_dp import tacs_pkg::*; #(
	parameter int MAX_OBJECTS = 16,
	parameter int CW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [CW-1:0]       cur_obj,
	input  logic [3:0]          object_index,
	input  logic [4:0]          word_index,
	input  logic signed [31:0]  word_value,
	input  logic signed [31:0]  player_min_x,
	input  logic signed [31:0]  player_min_y,
	input  logic signed [31:0]  player_min_z,
	input  logic signed [31:0]  player_max_x,
	input  logic signed [31:0]  player_max_y,
	input  logic signed [31:0]  player_max_z,
	output stat_t               stat
);

	localparam int DEPTH = MAX_OBJECTS * WORDS_PER_OBJ;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

	logic [31:0] mem [DEPTH];
	logic [MAX_OBJECTS-1:0] en_q;
	logic signed [31:0] rd_data_q;
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];
	logic signed [31:0] pmin_q [3];
	logic signed [31:0] pmax_q [3];
	logic signed [31:0] omin_q [3];
	logic signed [31:0] omax_q [3];
	logic signed [63:0] prod_q;
	logic signed [33:0] acc_q;

	logic [13:0] wr_full, rd_full;
	logic        obj_ok, cur_ok;
	logic signed [31:0] vsel, tval, psat;
	logic signed [47:0] pshift;

	assign obj_ok  = 9'(object_index) < 9'(MAX_OBJECTS);
	assign cur_ok  = 9'(cur_obj) < 9'(MAX_OBJECTS);
	assign wr_full = (14'(object_index) << 4) + (14'(object_index) << 1) + 14'(word_index);
	assign rd_full = (14'(cur_obj) << 4) + (14'(cur_obj) << 1) + 14'(cmd.rd_word);

	// corner bit picks min or max of the box on that axis
	assign vsel   = cmd.corner[cmd.col] ? bmax_q[cmd.col] : bmin_q[cmd.col];
	assign pshift = prod_q[63:16];
	assign psat   = sat48(pshift);
	assign tval   = sat34(acc_q);

	always_ff @(posedge clk) begin
		if (cmd.wr && obj_ok && word_index < 5'(WORDS_PER_OBJ))
			mem[AW'(wr_full)] <= word_value;
		if (cmd.rd_en)
			rd_data_q <= mem[AW'(rd_full)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
		end else if (cmd.wr && obj_ok && word_index == ENABLE_WORD) begin
			en_q[IW'(object_index)] <= word_value[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_player) begin
			pmin_q[0] <= player_min_x;
			pmin_q[1] <= player_min_y;
			pmin_q[2] <= player_min_z;
			pmax_q[0] <= player_max_x;
			pmax_q[1] <= player_max_y;
			pmax_q[2] <= player_max_z;
		end
		if (cmd.cap_box) begin
			if (cmd.box_sel < 3'd3)
				bmin_q[cmd.box_sel[1:0]] <= rd_data_q;
			else
				bmax_q[2'(cmd.box_sel - 3'd3)] <= rd_data_q;
		end
		if (cmd.mul)
			prod_q <= 64'(rd_data_q) * 64'(vsel);
		if (cmd.ld_acc)
			acc_q <= 34'(rd_data_q);
		else if (cmd.acc)
			acc_q <= acc_q + 34'(psat);
		if (cmd.clr) begin
			for (int a = 0; a < 3; a++) begin
				omin_q[a] <= S32_MAX;
				omax_q[a] <= S32_MIN;
			end
		end else if (cmd.fold) begin
			if (tval < omin_q[cmd.row])
				omin_q[cmd.row] <= tval;
			if (tval > omax_q[cmd.row])
				omax_q[cmd.row] <= tval;
		end
	end

	always_comb begin
		stat.en_cur  = cur_ok && en_q[IW'(cur_obj)];
		stat.overlap = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (!(pmin_q[a] <= omax_q[a] && pmax_q[a] >= omin_q[a]))
				stat.overlap = 1'b0;
		end
	end

endmodule

[rtl/tacs_ctrl.sv]
// controller: request handshake, object/corner/row/column sequencing, result register
// depends on tacs_pkg
module tacs_ctrl import tacs_pkg::*; #(
	parameter int MAX_OBJECTS = 16,
	parameter int CW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          req_type,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          hit,
	output logic [3:0]    hit_index,
	output cmd_t          cmd,
	output logic [CW-1:0] cur_obj,
	input  stat_t         stat
);

	state_t state_q, state_d;
	logic [CW-1:0] i_q;
	logic [2:0] cnt_q, k_q;
	logic [1:0] r_q, c_q;
	logic res_hit_q, out_valid_q, hit_q;
	logic [3:0] hit_index_q;
	logic accept, at_end, free, produce, prod_hit;
	logic [8:0] i_ext;

	assign free    = !out_valid_q || !out_stall;
	assign accept  = in_valid && !in_stall;
	assign at_end  = i_q == CW'(MAX_OBJECTS);
	assign i_ext   = 9'(i_q);
	assign cur_obj = i_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept && req_type == REQ_QUERY) state_d = ST_SCAN;
			ST_SCAN: begin
				if (at_end)
					state_d = ST_DONE;
				else if (stat.en_cur)
					state_d = ST_BOX;
			end
			ST_BOX:   if (cnt_q == BOX_DONE) state_d = ST_TRD;
			ST_TRD:   state_d = ST_TLD;
			ST_TLD:   state_d = ST_MUL;
			ST_MUL:   state_d = ST_ACC;
			ST_ACC:   state_d = (c_q == LAST_COL) ? ST_FOLD : ST_MUL;
			ST_FOLD: begin
				if (r_q == LAST_ROW && k_q == LAST_CORNER)
					state_d = ST_CHECK;
				else
					state_d = ST_TRD;
			end
			ST_CHECK: state_d = stat.overlap ? ST_DONE : ST_SCAN;
			ST_DONE:  if (free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.row = r_q;
		cmd.col = c_q;
		cmd.corner = k_q;
		in_stall = (state_q != ST_IDLE) || !free;
		produce = 1'b0;
		prod_hit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_WRITE) begin
						cmd.wr = 1'b1;
						produce = 1'b1;
					end else begin
						cmd.ld_player = 1'b1;
					end
				end
			end
			ST_SCAN:  cmd.clr = !at_end && stat.en_cur;
			ST_BOX: begin
				if (cnt_q < 3'(BOX_WORDS)) begin
					cmd.rd_en = 1'b1;
					cmd.rd_word = 5'(cnt_q);
				end
				if (cnt_q != 3'd0) begin
					cmd.cap_box = 1'b1;
					cmd.box_sel = cnt_q - 3'd1;
				end
			end
			ST_TRD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_word = TRANS_BASE + {1'b0, r_q, 2'b00};
			end
			ST_TLD: begin
				cmd.ld_acc = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_word = MAT_BASE + {1'b0, r_q, 2'b00};
			end
			ST_MUL:   cmd.mul = 1'b1;
			ST_ACC: begin
				cmd.acc = 1'b1;
				if (c_q != LAST_COL) begin
					cmd.rd_en = 1'b1;
					cmd.rd_word = MAT_BASE + {1'b0, r_q, 2'b00} + {3'b000, c_q} + 5'd1;
				end
			end
			ST_FOLD:  cmd.fold = 1'b1;
			ST_CHECK: ;
			ST_DONE: begin
				produce = free;
				prod_hit = res_hit_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0;
			cnt_q <= '0;
			k_q <= '0;
			r_q <= '0;
			c_q <= '0;
			res_hit_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_QUERY) begin
						i_q <= '0;
						res_hit_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (!at_end && !stat.en_cur)
						i_q <= i_q + 1'b1;
					cnt_q <= '0;
				end
				ST_BOX: begin
					cnt_q <= cnt_q + 3'd1;
					k_q <= '0;
					r_q <= '0;
				end
				ST_TLD:   c_q <= '0;
				ST_ACC:   if (c_q != LAST_COL) c_q <= c_q + 2'd1;
				ST_FOLD: begin
					if (r_q != LAST_ROW) begin
						r_q <= r_q + 2'd1;
					end else begin
						r_q <= '0;
						k_q <= k_q + 3'd1;
					end
				end
				ST_CHECK: begin
					if (stat.overlap)
						res_hit_q <= 1'b1;
					else
						i_q <= i_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result register parts the input side from the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (produce) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			hit_q <= prod_hit;
			hit_index_q <= prod_hit ? i_ext[3:0] : 4'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign hit = hit_q;
	assign hit_index = hit_index_q;

endmodule

[rtl/transformed_aabb_collision_scan_unit.sv]
// A write item gives its result in the cycle after acceptance.
// A query takes a scan slot per disabled object and, per enabled object it examines, a scan
// slot, six box word loads, 24 corner rows on one shared multiplier and memory read port,
// and an overlap check.
// One item at a time; the next is taken once the result register is empty or read that cycle.
// Reset (arst_n low, asynchronous) clears control state and all enable bits.
module transformed_aabb_collision_scan_unit import tacs_pkg::*; #(
	parameter int MAX_OBJECTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [3:0]         object_index,
	input  logic [4:0]         word_index,
	input  logic signed [31:0] word_value,
	input  logic signed [31:0] player_min_x,
	input  logic signed [31:0] player_min_y,
	input  logic signed [31:0] player_min_z,
	input  logic signed [31:0] player_max_x,
	input  logic signed [31:0] player_max_y,
	input  logic signed [31:0] player_max_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               hit,
	output logic [3:0]         hit_index
);

	localparam int CW = ((MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1) + 1;

	cmd_t cmd;
	stat_t stat;
	logic [CW-1:0] cur_obj;

	tacs_ctrl #(.MAX_OBJECTS(MAX_OBJECTS), .CW(CW)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .req_type(req_type),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .hit_index(hit_index),
		.cmd(cmd), .cur_obj(cur_obj), .stat(stat)
	);

	tacs_dp #(.MAX_OBJECTS(MAX_OBJECTS), .CW(CW)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .cur_obj(cur_obj),
		.object_index(object_index), .word_index(word_index), .word_value(word_value),
		.player_min_x(player_min_x), .player_min_y(player_min_y),
		.player_min_z(player_min_z), .player_max_x(player_max_x),
		.player_max_y(player_max_y), .player_max_z(player_max_z),
		.stat(stat)
	);

endmodule

[rtl/tacs_checker.sv]
// port-level checks for the collision scan unit, bound to the top level
// depends on transformed_aabb_collision_scan_unit_defines.svh
`include "transformed_aabb_collision_scan_unit_defines.svh"
module tacs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       req_type,
	input logic       out_valid,
	input logic       out_stall,
	input logic       hit,
	input logic [3:0] hit_index
);

	`TACS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`TACS_ASSERT_NOW(a_miss_idx_zero, out_valid && !hit, hit_index == 4'd0)
	`TACS_ASSERT_NEXT(a_write_result, in_valid && !in_stall && !req_type, out_valid && !hit)
	`TACS_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && req_type, in_stall)

endmodule

bind transformed_aabb_collision_scan_unit tacs_checker u_tacs_checker (.*);

[bench/transformed_aabb_collision_scan_unit_test.sv]
// testbench for the transformed box collision scan unit: random object loads and queries
// checked against a fixed-point predictor held in a small scoreboard class; needs tacs_pkg
module transformed_aabb_collision_scan_unit_test;
	import tacs_pkg::*;

	typedef struct {
		logic               req;
		logic [3:0]         obj;
		logic [4:0]         wi;
		logic signed [31:0] wv;
		logic signed [31:0] pmin [3];
		logic signed [31:0] pmax [3];
	} item_t;

	typedef struct {
		logic       hit;
		logic [3:0] idx;
	} verdict_t;

	class collision_scoreboard;
		logic signed [31:0] words [16][18];
		logic               enabled [16];
		verdict_t           verdicts [$];
		int                 errors;

		function new();
			errors = 0;
			foreach (enabled[i]) enabled[i] = 1'b0;
			foreach (words[i, j]) words[i][j] = '0;
		endfunction

		function logic signed [31:0] clamp32(longint v);
			logic signed [31:0] r;
			if (v > longint'(S32_MAX))
				r = S32_MAX;
			else if (v < longint'(S32_MIN))
				r = S32_MIN;
			else
				r = v[31:0];
			return r;
		endfunction

		// arithmetic shift of a signed product rounds toward minus infinity
		function logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
			longint p;
			p = longint'(a) * longint'(b);
			return clamp32(p >>> 16);
		endfunction

		function bit box_overlaps(int o, logic signed [31:0] pmin [3],
				logic signed [31:0] pmax [3]);
			logic signed [31:0] lo [3], hi [3], v [3], t;
			longint acc;
			for (int r = 0; r < 3; r++) begin
				lo[r] = S32_MAX;
				hi[r] = S32_MIN;
			end
			for (int k = 0; k < 8; k++) begin
				for (int c = 0; c < 3; c++)
					v[c] = k[c] ? words[o][3 + c] : words[o][c];
				for (int r = 0; r < 3; r++) begin
					acc = longint'(words[o][6 + 4 * r + 3]);
					for (int c = 0; c < 3; c++)
						acc += longint'(fx_mul(words[o][6 + 4 * r + c], v[c]));
					t = clamp32(acc);
					if (t < lo[r]) lo[r] = t;
					if (t > hi[r]) hi[r] = t;
				end
			end
			for (int r = 0; r < 3; r++)
				if (!(pmin[r] <= hi[r] && pmax[r] >= lo[r]))
					return 0;
			return 1;
		endfunction

		function void note_item(item_t it);
			verdict_t e;
			e.hit = 1'b0;
			e.idx = '0;
			if (it.req == REQ_WRITE) begin
				if (it.wi < ENABLE_WORD)
					words[it.obj][it.wi] = it.wv;
				else if (it.wi == ENABLE_WORD)
					enabled[it.obj] = it.wv[0];
			end else begin
				for (int i = 0; i < 16; i++)
					if (enabled[i] && box_overlaps(i, it.pmin, it.pmax)) begin
						e.hit = 1'b1;
						e.idx = 4'(i);
						break;
					end
			end
			verdicts = {verdicts, e};
		endfunction

		function void check_result(logic h, logic [3:0] idx);
			verdict_t e;
			if (verdicts.size() == 0) begin
				$error("unexpected result hit=%0d hit_index=%0d", h, idx);
				errors++;
				return;
			end
			e = verdicts.pop_front();
			if (h !== e.hit) begin
				$error("hit: expected %0d actual %0d", e.hit, h);
				errors++;
			end
			if (idx !== e.idx) begin
				$error("hit_index: expected %0d actual %0d", e.idx, idx);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               req_type = 1'b0;
	logic [3:0]         object_index = '0;
	logic [4:0]         word_index = '0;
	logic signed [31:0] word_value = '0;
	logic signed [31:0] player_min_x = '0, player_min_y = '0, player_min_z = '0;
	logic signed [31:0] player_max_x = '0, player_max_y = '0, player_max_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               hit;
	logic [3:0]         hit_index;

	collision_scoreboard sb = new();
	bit                  idling = 1'b1;
	bit                  loaded [16];
	int                  items_left;

	transformed_aabb_collision_scan_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#100_000_000;
		$display("FAIL transformed_aabb_collision_scan_unit");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(hit, hit_index);

	// receiver stalls in short bursts
	initial begin
		forever begin
			@(negedge clk);
			if (idling && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	function automatic logic signed [31:0] rand_q();
		case ($urandom_range(0, 11))
			0: return $urandom;
			1: return S32_MAX;
			2: return S32_MIN;
			default: return $signed(32'($urandom_range(0, 20 << 16))) - (10 << 16);
		endcase
	endfunction

	task automatic send(item_t it);
		if (idling && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= it.req;
		object_index <= it.obj;
		word_index   <= it.wi;
		word_value   <= it.wv;
		player_min_x <= it.pmin[0];
		player_min_y <= it.pmin[1];
		player_min_z <= it.pmin[2];
		player_max_x <= it.pmax[0];
		player_max_y <= it.pmax[1];
		player_max_z <= it.pmax[2];
		do @(posedge clk); while (in_stall);
		sb.note_item(it);
		items_left--;
		@(negedge clk);
	endtask

	function automatic item_t noise_item();
		item_t it;
		it.req = REQ_WRITE;
		it.obj = 4'($urandom);
		it.wi  = 5'($urandom);
		it.wv  = $urandom;
		// an object may only be enabled once all its words hold data
		if (it.wi == ENABLE_WORD && !loaded[it.obj]) it.wv[0] = 1'b0;
		for (int k = 0; k < 3; k++) begin
			it.pmin[k] = $urandom;
			it.pmax[k] = $urandom;
		end
		return it;
	endfunction

	task automatic write_word(int o, int w, logic signed [31:0] v);
		item_t it;
		it = noise_item();
		it.obj = 4'(o);
		it.wi  = 5'(w);
		// an object may only be enabled once all its words hold data
		if (w == ENABLE_WORD && !loaded[o]) v[0] = 1'b0;
		it.wv  = v;
		send(it);
	endtask

	task automatic query(logic signed [31:0] lo [3], logic signed [31:0] hi [3]);
		item_t it;
		it = noise_item();
		it.req = REQ_QUERY;
		it.pmin = lo;
		it.pmax = hi;
		send(it);
	endtask

	task automatic load_object(int o, bit wild, bit en);
		logic signed [31:0] v, lo;
		for (int c = 0; c < 3; c++) begin
			lo = wild ? rand_q() : $signed(32'($urandom_range(0, 16 << 16))) - (8 << 16);
			write_word(o, c, lo);
			v = wild ? rand_q() : lo + $signed(32'($urandom_range(0, 4 << 16)));
			write_word(o, 3 + c, v);
		end
		for (int w = 6; w < 18; w++) begin
			if (wild)
				v = rand_q();
			else if ((w - 6) % 4 == 3)
				v = $signed(32'($urandom_range(0, 8 << 16))) - (4 << 16);
			else if ((w - 6) % 4 == (w - 6) / 4)
				v = 32'sh10000 + $signed(32'($urandom_range(0, 1 << 16))) - (1 << 15);
			else
				v = $signed(32'($urandom_range(0, 1 << 15))) - (1 << 14);
			write_word(o, w, v);
		end
		loaded[o] = 1'b1;
		write_word(o, ENABLE_WORD, {31'($urandom_range(0, 1 << 30)), en});
	endtask

	task automatic random_query();
		logic signed [31:0] lo [3], hi [3];
		for (int k = 0; k < 3; k++) begin
			if ($urandom_range(0, 9) == 0) begin
				lo[k] = $urandom;
				hi[k] = $urandom;
			end else begin
				lo[k] = $signed(32'($urandom_range(0, 24 << 16))) - (12 << 16);
				hi[k] = lo[k] + $signed(32'($urandom_range(0, 6 << 16))) - (1 << 16);
			end
		end
		query(lo, hi);
	endtask

	initial begin
		logic signed [31:0] lo [3], hi [3];
		bit drained;
		drained = 1'b0;
		foreach (loaded[i]) loaded[i] = 1'b0;
		items_left = 750;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// nothing enabled yet
		lo = '{S32_MIN, S32_MIN, S32_MIN};
		hi = '{S32_MAX, S32_MAX, S32_MAX};
		query(lo, hi);
		// unit box with identity matrix at object 0
		for (int w = 0; w < 18; w++)
			write_word(0, w, (w >= 3 && w < 6) || (w >= 6 && (w - 6) % 5 == 0) ? 32'sh10000 : 0);
		loaded[0] = 1'b1;
		write_word(0, ENABLE_WORD, 32'shfffffffe);	// bit 0 clear keeps it off
		query(lo, hi);
		write_word(0, ENABLE_WORD, 32'sh3);
		write_word(0, 31, 32'sh7);					// out of range word, dropped
		// touching faces count as overlap
		lo = '{32'sh10000, 32'sh10000, 32'sh10000};
		hi = '{32'sh20000, 32'sh20000, 32'sh20000};
		query(lo, hi);
		lo = '{32'sh10001, 32'sh0, 32'sh0};
		query(lo, hi);
		// inverted player box is not swapped
		lo = '{32'sh10000, 32'sh10000, 32'sh10000};
		hi = '{32'sh0, 32'sh0, 32'sh0};
		query(lo, hi);
		// extreme words drive products and sums into saturation
		for (int w = 0; w < 18; w++)
			write_word(15, w, w % 2 ? S32_MAX : S32_MIN);
		loaded[15] = 1'b1;
		write_word(15, ENABLE_WORD, 32'sh1);
		write_word(0, ENABLE_WORD, 32'sh0);
		lo = '{S32_MAX, S32_MAX, S32_MAX};
		hi = '{S32_MAX, S32_MAX, S32_MAX};
		query(lo, hi);

		while (items_left > 0) begin
			// no item is offered between sends
			in_valid <= 1'b0;
			if (items_left < 100) idling = 1'b0;
			if (!drained && items_left <= 400) begin
				drained = 1'b1;
				wait (sb.verdicts.size() == 0);
			end
			@(negedge clk);
			case ($urandom_range(0, 9))
				0, 1: load_object($urandom_range(0, 15), $urandom_range(0, 7) == 0,
					$urandom_range(0, 2) != 0);
				2: write_word($urandom_range(0, 15), $urandom_range(0, 18), rand_q());
				3: write_word($urandom_range(0, 15), ENABLE_WORD, $urandom);
				4: send(noise_item());
				default: random_query();
			endcase
		end

		in_valid <= 1'b0;
		wait (sb.verdicts.size() == 0);
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.verdicts.size() == 0)
			$display("PASS transformed_aabb_collision_scan_unit");
		else
			$display("FAIL transformed_aabb_collision_scan_unit");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/tacs_pkg.sv
rtl/tacs_dp.sv
rtl/tacs_ctrl.sv
rtl/transformed_aabb_collision_scan_unit.sv
rtl/tacs_checker.sv
bench/transformed_aabb_collision_scan_unit_test.sv
